[design/dmip_pkg.sv]
// ----------------------------------------------------------------------------
// dmip_pkg
// Shared constants and types of the dual-wheel incremental PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dmip_pkg;

	localparam int GAIN_W         = 16;
	localparam int GAIN_FRAC_BITS = 8;
	localparam int DRIVE_LIMIT    = 990;
	localparam int SPEED_CAP      = 400;
	localparam int DUTY_SCALE     = 10;

	localparam int CNT_W     = 16;
	localparam int TGT_W     = 11;
	localparam int ERR_W     = 18;
	localparam int K_W       = GAIN_W + 2;
	localparam int PROD_W    = K_W + 1 + ERR_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int INC_W     = SUM_W - GAIN_FRAC_BITS;
	localparam int DRV_W     = 11;
	localparam int DUTY_W    = 14;
	localparam int AVG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 56;
	localparam int OUT_W     = 96;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P = 2'd0,
		CFG_GAIN_I = 2'd1,
		CFG_GAIN_D = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] e0;
		logic signed [ERR_W-1:0] e1;
		logic signed [ERR_W-1:0] e2;
	} err_hist_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic upd;
	} pipe_ctl_t;

	typedef struct packed {
		logic [K_W-1:0]    k0;
		logic [K_W-1:0]    k1;
		logic [GAIN_W-1:0] kd;
	} gain_set_t;

endpackage

`default_nettype wire

[design/dmip_front.sv]
// ----------------------------------------------------------------------------
// dmip_front
// Count capping, speed average and the error history of both wheels.
// ----------------------------------------------------------------------------
`default_nettype none

module dmip_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [dmip_pkg::CNT_W-1:0]   right_count,
	input  logic signed [dmip_pkg::CNT_W-1:0]   left_count,
	input  logic signed [dmip_pkg::TGT_W-1:0]   left_target,
	input  logic signed [dmip_pkg::TGT_W-1:0]   right_target,
	output dmip_pkg::err_hist_t                 left_hist,
	output dmip_pkg::err_hist_t                 right_hist,
	output logic signed [dmip_pkg::AVG_W-1:0]   avg_s1
);
	import dmip_pkg::*;

	localparam logic signed [CNT_W:0] CAP = (CNT_W+1)'(SPEED_CAP);

	logic signed [CNT_W:0]   rc_w, lc_w, rc_cap, lc_cap;
	logic signed [CNT_W+1:0] sum_w, sum_adj;
	logic signed [ERR_W-1:0] l_err, r_err;

	always_comb begin
		rc_w    = {right_count[CNT_W-1], right_count};
		lc_w    = -{left_count[CNT_W-1], left_count};
		rc_cap  = (rc_w > CAP) ? CAP : rc_w;
		lc_cap  = (lc_w > CAP) ? CAP : lc_w;
		sum_w   = {rc_cap[CNT_W], rc_cap} + {lc_cap[CNT_W], lc_cap};
		// round toward zero
		sum_adj = sum_w + (CNT_W+2)'(sum_w[CNT_W+1]);
		l_err   = ERR_W'(left_target) - ERR_W'(lc_cap);
		r_err   = ERR_W'(right_target) - ERR_W'(rc_cap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hist  <= '0;
			right_hist <= '0;
		end else if (load) begin
			left_hist  <= '{e0: l_err, e1: left_hist.e0, e2: left_hist.e1};
			right_hist <= '{e0: r_err, e1: right_hist.e0, e2: right_hist.e1};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			avg_s1 <= sum_adj[AVG_W:1];
		end
	end

endmodule

`default_nettype wire

[design/dmip_wheel.sv]
// ----------------------------------------------------------------------------
// dmip_wheel
// One wheel: PID increment products, truncation, saturating drive and duties.
// ----------------------------------------------------------------------------
`default_nettype none

module dmip_wheel (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmip_pkg::pipe_ctl_t                  ctl,
	input  dmip_pkg::gain_set_t                  gains,
	input  dmip_pkg::err_hist_t                  hist,
	output logic signed [dmip_pkg::DRV_W-1:0]    drive_q,
	output logic        [dmip_pkg::DUTY_W-1:0]   pos_q,
	output logic        [dmip_pkg::DUTY_W-1:0]   neg_q
);
	import dmip_pkg::*;

	localparam logic signed [INC_W:0] LIM_HI = (INC_W+1)'(DRIVE_LIMIT);
	localparam logic signed [INC_W:0] LIM_LO = -(INC_W+1)'(DRIVE_LIMIT);
	localparam logic [SUM_W-1:0]      BIAS   = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

	logic signed [PROD_W-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [INC_W-1:0]  inc_s3;
	logic signed [SUM_W-1:0]  sum, sum_adj;
	logic signed [INC_W:0]    nxt_w, sat_w;
	logic signed [DRV_W-1:0]  nxt;
	logic        [DRV_W-1:0]  mag;
	logic        [DUTY_W-1:0] duty;

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			p0_s2 <= $signed({1'b0, gains.k0}) * hist.e0;
			p1_s2 <= $signed({1'b0, gains.k1}) * hist.e1;
			p2_s2 <= $signed({1'b0, gains.kd}) * hist.e2;
		end
		if (ctl.ld_s3) begin
			inc_s3 <= sum_adj[SUM_W-1:GAIN_FRAC_BITS];
		end
	end

	always_comb begin
		sum     = SUM_W'(p0_s2) - SUM_W'(p1_s2) + SUM_W'(p2_s2);
		// bias negative sums so the shift truncates toward zero
		sum_adj = sum + (sum[SUM_W-1] ? BIAS : '0);
		nxt_w   = {{(INC_W+1-DRV_W){drive_q[DRV_W-1]}}, drive_q} + {inc_s3[INC_W-1], inc_s3};
		if (nxt_w > LIM_HI) begin
			sat_w = LIM_HI;
		end else if (nxt_w < LIM_LO) begin
			sat_w = LIM_LO;
		end else begin
			sat_w = nxt_w;
		end
		nxt  = sat_w[DRV_W-1:0];
		mag  = nxt[DRV_W-1] ? DRV_W'(-nxt) : DRV_W'(nxt);
		duty = DUTY_W'(mag) * DUTY_W'(DUTY_SCALE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= '0;
			pos_q   <= '0;
			neg_q   <= '0;
		end else if (ctl.upd) begin
			drive_q <= nxt;
			pos_q   <= (nxt > 0) ? duty : '0;
			neg_q   <= (nxt > 0) ? '0 : duty;
		end
	end

endmodule

`default_nettype wire

[design/dual_motor_incremental_pid.sv]
// ----------------------------------------------------------------------------
// dual_motor_incremental_pid
// Two-wheel velocity-form PID speed controller with H-bridge duty outputs.
// ----------------------------------------------------------------------------
// One item per clock sustained while the output side accepts. A result is
// offered on the fourth register: error capture, gain products, increment
// sum and truncation, then the saturating drive accumulator, which closes
// its loop inside the output stage. An output stall holds each full stage
// up to the first empty one and backs up to the input when none is empty.
// Gain writes take effect for items accepted from the next cycle on.
`default_nettype none

module dual_motor_incremental_pid (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dmip_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dmip_pkg::GAIN_W-1:0]          cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// right_count, left_count, left_target, right_target, zero pad
	input  logic [dmip_pkg::IN_W-1:0]            s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// left_drive, right_drive, right_pos_duty, right_neg_duty,
	// left_pos_duty, left_neg_duty, average_speed, zero pad
	output logic [dmip_pkg::OUT_W-1:0]           m_tdata
);
	import dmip_pkg::*;

	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	gain_set_t         gains_q;

	logic              v_s1, v_s2, v_s3, v_q;
	logic              en_o, en3, en2, en1, s_fire;
	pipe_ctl_t         ctl;

	err_hist_t         left_hist, right_hist;
	logic signed [AVG_W-1:0] avg_s1, avg_s2, avg_s3, avg_q;

	logic signed [DRV_W-1:0]  l_drv, r_drv;
	logic        [DUTY_W-1:0] l_pos, l_neg, r_pos, r_neg;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			gains_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_GAIN_P: gain_p_q <= cfg_data;
					CFG_GAIN_I: gain_i_q <= cfg_data;
					CFG_GAIN_D: gain_d_q <= cfg_data;
					default: ;
				endcase
			end
			gains_q.k0 <= K_W'(gain_p_q) + K_W'(gain_i_q) + K_W'(gain_d_q);
			gains_q.k1 <= K_W'(gain_p_q) + {1'b0, gain_d_q, 1'b0};
			gains_q.kd <= gain_d_q;
		end
	end

	assign en_o     = !v_q || m_tready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign s_fire   = s_tvalid && en1;

	assign ctl.ld_s2 = en2 && v_s1;
	assign ctl.ld_s3 = en3 && v_s2;
	assign ctl.upd   = en_o && v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en_o) v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) avg_s2 <= avg_s1;
		if (ctl.ld_s3) avg_s3 <= avg_s2;
		if (ctl.upd)   avg_q  <= avg_s3;
	end

	dmip_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (s_fire),
		.right_count  (s_tdata[15:0]),
		.left_count   (s_tdata[31:16]),
		.left_target  (s_tdata[42:32]),
		.right_target (s_tdata[53:43]),
		.left_hist    (left_hist),
		.right_hist   (right_hist),
		.avg_s1       (avg_s1)
	);

	dmip_wheel u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.gains   (gains_q),
		.hist    (left_hist),
		.drive_q (l_drv),
		.pos_q   (l_pos),
		.neg_q   (l_neg)
	);

	dmip_wheel u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.gains   (gains_q),
		.hist    (right_hist),
		.drive_q (r_drv),
		.pos_q   (r_pos),
		.neg_q   (r_neg)
	);

	assign m_tvalid = v_q;
	assign m_tdata  = {2'b00, avg_q, l_neg, l_pos, r_neg, r_pos, r_drv, l_drv};

endmodule

`default_nettype wire

[design/dmip_chk.sv]
// ----------------------------------------------------------------------------
// dmip_chk
// Port-level checks of the dual-wheel PID controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dmip_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tready,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [dmip_pkg::OUT_W-1:0]         m_tdata
);
	import dmip_pkg::*;

	logic signed [DRV_W-1:0] l_drv, r_drv;

	assign l_drv = m_tdata[10:0];
	assign r_drv = m_tdata[21:11];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transfer changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> l_drv <= 11'sd990 && l_drv >= -11'sd990 &&
			r_drv <= 11'sd990 && r_drv >= -11'sd990)
		else $error("drive beyond limit");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[35:22] == '0 || m_tdata[49:36] == '0) &&
			(m_tdata[63:50] == '0 || m_tdata[77:64] == '0))
		else $error("both bridge sides driven");

	a_pos_side: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_drv > 0 |-> m_tdata[49:36] == '0 && m_tdata[35:22] != '0)
		else $error("positive drive on wrong side");

endmodule

bind dual_motor_incremental_pid dmip_chk u_dmip_chk (.*);

`default_nettype wire
